// ===== hdl/rvid_pkg.sv =====
package rvid_pkg;

    localparam int unsigned INSTR_W = 32;
    localparam int unsigned ENTRY_W = 6;
    localparam int unsigned FMT_W   = 3;
    localparam int unsigned SRC_W   = 2;
    localparam int unsigned OP_W    = 4;
    localparam int unsigned WB_W    = 2;
    localparam int unsigned MSZ_W   = 2;
    localparam int unsigned CF_W    = 3;
    localparam int unsigned CMP_W   = 3;

    // major opcodes
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_JAL      = 7'h6f;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_OP_IMM   = 7'h13;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;

    localparam logic [6:0]  FUNCT7_ZERO = 7'b0000000;
    localparam logic [6:0]  FUNCT7_ALT  = 7'b0100000;
    localparam logic [11:0] IMM_ECALL   = 12'b000000000000;
    localparam logic [11:0] IMM_EBREAK  = 12'b000000000001;

    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    // instruction index
    localparam logic [ENTRY_W-1:0] E_LUI     = 6'd0;
    localparam logic [ENTRY_W-1:0] E_AUIPC   = 6'd1;
    localparam logic [ENTRY_W-1:0] E_JAL     = 6'd2;
    localparam logic [ENTRY_W-1:0] E_JALR    = 6'd3;
    localparam logic [ENTRY_W-1:0] E_BEQ     = 6'd4;
    localparam logic [ENTRY_W-1:0] E_BNE     = 6'd5;
    localparam logic [ENTRY_W-1:0] E_BLT     = 6'd6;
    localparam logic [ENTRY_W-1:0] E_BGE     = 6'd7;
    localparam logic [ENTRY_W-1:0] E_BLTU    = 6'd8;
    localparam logic [ENTRY_W-1:0] E_BGEU    = 6'd9;
    localparam logic [ENTRY_W-1:0] E_LB      = 6'd10;
    localparam logic [ENTRY_W-1:0] E_LH      = 6'd11;
    localparam logic [ENTRY_W-1:0] E_LW      = 6'd12;
    localparam logic [ENTRY_W-1:0] E_LBU     = 6'd13;
    localparam logic [ENTRY_W-1:0] E_LHU     = 6'd14;
    localparam logic [ENTRY_W-1:0] E_SB      = 6'd15;
    localparam logic [ENTRY_W-1:0] E_SH      = 6'd16;
    localparam logic [ENTRY_W-1:0] E_SW      = 6'd17;
    localparam logic [ENTRY_W-1:0] E_ADDI    = 6'd18;
    localparam logic [ENTRY_W-1:0] E_SLTI    = 6'd19;
    localparam logic [ENTRY_W-1:0] E_SLTIU   = 6'd20;
    localparam logic [ENTRY_W-1:0] E_XORI    = 6'd21;
    localparam logic [ENTRY_W-1:0] E_ORI     = 6'd22;
    localparam logic [ENTRY_W-1:0] E_ANDI    = 6'd23;
    localparam logic [ENTRY_W-1:0] E_SLLI    = 6'd24;
    localparam logic [ENTRY_W-1:0] E_SRLI    = 6'd25;
    localparam logic [ENTRY_W-1:0] E_SRAI    = 6'd26;
    localparam logic [ENTRY_W-1:0] E_ADD     = 6'd27;
    localparam logic [ENTRY_W-1:0] E_SUB     = 6'd28;
    localparam logic [ENTRY_W-1:0] E_SLL     = 6'd29;
    localparam logic [ENTRY_W-1:0] E_SLT     = 6'd30;
    localparam logic [ENTRY_W-1:0] E_SLTU    = 6'd31;
    localparam logic [ENTRY_W-1:0] E_XOR     = 6'd32;
    localparam logic [ENTRY_W-1:0] E_SRL     = 6'd33;
    localparam logic [ENTRY_W-1:0] E_SRA     = 6'd34;
    localparam logic [ENTRY_W-1:0] E_OR      = 6'd35;
    localparam logic [ENTRY_W-1:0] E_AND     = 6'd36;
    localparam logic [ENTRY_W-1:0] E_FENCE   = 6'd37;
    localparam logic [ENTRY_W-1:0] E_ECALL   = 6'd38;
    localparam logic [ENTRY_W-1:0] E_EBREAK  = 6'd39;
    localparam logic [ENTRY_W-1:0] E_UNKNOWN = 6'd40;

    localparam logic [FMT_W-1:0] FMT_R   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_I   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_S   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_B   = 3'd3;
    localparam logic [FMT_W-1:0] FMT_U   = 3'd4;
    localparam logic [FMT_W-1:0] FMT_J   = 3'd5;
    localparam logic [FMT_W-1:0] FMT_UNK = 3'd6;

    localparam logic [SRC_W-1:0] SRC_NONE = 2'd0;
    localparam logic [SRC_W-1:0] SRC_REG  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_PC   = 2'd2;
    localparam logic [SRC_W-1:0] SRC_IMM  = 2'd3;

    localparam logic [OP_W-1:0] ALU_NONE   = 4'd0;
    localparam logic [OP_W-1:0] ALU_PASS_B = 4'd1;
    localparam logic [OP_W-1:0] ALU_ADD    = 4'd2;
    localparam logic [OP_W-1:0] ALU_SUB    = 4'd3;
    localparam logic [OP_W-1:0] ALU_SLL    = 4'd4;
    localparam logic [OP_W-1:0] ALU_SLT    = 4'd5;
    localparam logic [OP_W-1:0] ALU_SLTU   = 4'd6;
    localparam logic [OP_W-1:0] ALU_XOR    = 4'd7;
    localparam logic [OP_W-1:0] ALU_SRL    = 4'd8;
    localparam logic [OP_W-1:0] ALU_SRA    = 4'd9;
    localparam logic [OP_W-1:0] ALU_OR     = 4'd10;
    localparam logic [OP_W-1:0] ALU_AND    = 4'd11;

    localparam logic [WB_W-1:0] WB_NONE = 2'd0;
    localparam logic [WB_W-1:0] WB_ALU  = 2'd1;
    localparam logic [WB_W-1:0] WB_MEM  = 2'd2;
    localparam logic [WB_W-1:0] WB_PC   = 2'd3;

    localparam logic [MSZ_W-1:0] MSZ_NONE = 2'd0;
    localparam logic [MSZ_W-1:0] MSZ_BYTE = 2'd1;
    localparam logic [MSZ_W-1:0] MSZ_HALF = 2'd2;
    localparam logic [MSZ_W-1:0] MSZ_WORD = 2'd3;

    localparam logic [CF_W-1:0] CF_NONE   = 3'd0;
    localparam logic [CF_W-1:0] CF_BRANCH = 3'd1;
    localparam logic [CF_W-1:0] CF_JUMP   = 3'd2;
    localparam logic [CF_W-1:0] CF_JREG   = 3'd3;
    localparam logic [CF_W-1:0] CF_TRAP   = 3'd4;

    localparam logic [CMP_W-1:0] CMP_NONE = 3'd0;
    localparam logic [CMP_W-1:0] CMP_EQ   = 3'd1;
    localparam logic [CMP_W-1:0] CMP_NE   = 3'd2;
    localparam logic [CMP_W-1:0] CMP_LT   = 3'd3;
    localparam logic [CMP_W-1:0] CMP_GE   = 3'd4;
    localparam logic [CMP_W-1:0] CMP_LTU  = 3'd5;
    localparam logic [CMP_W-1:0] CMP_GEU  = 3'd6;

    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic [SRC_W-1:0] src_a;
        logic [SRC_W-1:0] src_b;
        logic [OP_W-1:0]  alu_op;
        logic [WB_W-1:0]  wb;
        logic [MSZ_W-1:0] msz;
        logic             mw;
        logic             mse;
        logic [CF_W-1:0]  cf;
        logic [CMP_W-1:0] cmp;
    } t_ctl_row;

    typedef struct packed {
        logic               legal;
        logic [ENTRY_W-1:0] entry;
        t_ctl_row           row;
    } t_dec;

    function automatic t_ctl_row mk_row(
        input logic [FMT_W-1:0] fmt,
        input logic [SRC_W-1:0] src_a,
        input logic [SRC_W-1:0] src_b,
        input logic [OP_W-1:0]  alu_op,
        input logic [WB_W-1:0]  wb,
        input logic [MSZ_W-1:0] msz,
        input logic             mw,
        input logic             mse,
        input logic [CF_W-1:0]  cf,
        input logic [CMP_W-1:0] cmp
    );
        t_ctl_row r;
        r.fmt    = fmt;
        r.src_a  = src_a;
        r.src_b  = src_b;
        r.alu_op = alu_op;
        r.wb     = wb;
        r.msz    = msz;
        r.mw     = mw;
        r.mse    = mse;
        r.cf     = cf;
        r.cmp    = cmp;
        return r;
    endfunction

    // control word for each instruction index
    function automatic t_ctl_row ctl_lookup(input logic [ENTRY_W-1:0] e);
        t_ctl_row r;
        case (e)
            E_LUI:    r = mk_row(FMT_U, SRC_NONE, SRC_IMM, ALU_PASS_B, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_AUIPC:  r = mk_row(FMT_U, SRC_PC, SRC_IMM, ALU_ADD, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_JAL:    r = mk_row(FMT_J, SRC_NONE, SRC_NONE, ALU_NONE, WB_PC, MSZ_NONE,
                                 1'b0, 1'b0, CF_JUMP, CMP_NONE);
            E_JALR:   r = mk_row(FMT_I, SRC_NONE, SRC_NONE, ALU_NONE, WB_PC, MSZ_NONE,
                                 1'b0, 1'b0, CF_JREG, CMP_NONE);
            E_BEQ:    r = mk_row(FMT_B, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_BRANCH, CMP_EQ);
            E_BNE:    r = mk_row(FMT_B, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_BRANCH, CMP_NE);
            E_BLT:    r = mk_row(FMT_B, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_BRANCH, CMP_LT);
            E_BGE:    r = mk_row(FMT_B, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_BRANCH, CMP_GE);
            E_BLTU:   r = mk_row(FMT_B, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_BRANCH, CMP_LTU);
            E_BGEU:   r = mk_row(FMT_B, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_BRANCH, CMP_GEU);
            E_LB:     r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_ADD, WB_MEM, MSZ_BYTE,
                                 1'b0, 1'b1, CF_NONE, CMP_NONE);
            E_LH:     r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_ADD, WB_MEM, MSZ_HALF,
                                 1'b0, 1'b1, CF_NONE, CMP_NONE);
            E_LW:     r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_ADD, WB_MEM, MSZ_WORD,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_LBU:    r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_ADD, WB_MEM, MSZ_BYTE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_LHU:    r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_ADD, WB_MEM, MSZ_HALF,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SB:     r = mk_row(FMT_S, SRC_REG, SRC_IMM, ALU_ADD, WB_NONE, MSZ_BYTE,
                                 1'b1, 1'b0, CF_NONE, CMP_NONE);
            E_SH:     r = mk_row(FMT_S, SRC_REG, SRC_IMM, ALU_ADD, WB_NONE, MSZ_HALF,
                                 1'b1, 1'b0, CF_NONE, CMP_NONE);
            E_SW:     r = mk_row(FMT_S, SRC_REG, SRC_IMM, ALU_ADD, WB_NONE, MSZ_WORD,
                                 1'b1, 1'b0, CF_NONE, CMP_NONE);
            E_ADDI:   r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_ADD, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SLTI:   r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_SLT, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SLTIU:  r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_SLTU, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_XORI:   r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_XOR, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_ORI:    r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_OR, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_ANDI:   r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_AND, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SLLI:   r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_SLL, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SRLI:   r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_SRL, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SRAI:   r = mk_row(FMT_I, SRC_REG, SRC_IMM, ALU_SRA, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_ADD:    r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_ADD, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SUB:    r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_SUB, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SLL:    r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_SLL, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SLT:    r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_SLT, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SLTU:   r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_SLTU, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_XOR:    r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_XOR, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SRL:    r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_SRL, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_SRA:    r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_SRA, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_OR:     r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_OR, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_AND:    r = mk_row(FMT_R, SRC_REG, SRC_REG, ALU_AND, WB_ALU, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_FENCE:  r = mk_row(FMT_I, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
            E_ECALL:  r = mk_row(FMT_I, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_TRAP, CMP_NONE);
            E_EBREAK: r = mk_row(FMT_I, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_TRAP, CMP_NONE);
            default:  r = mk_row(FMT_UNK, SRC_NONE, SRC_NONE, ALU_NONE, WB_NONE, MSZ_NONE,
                                 1'b0, 1'b0, CF_NONE, CMP_NONE);
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/rvid_instr_if.sv =====
interface rvid_instr_if import rvid_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INSTR_W-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink (input valid, input instruction, output ready);
endinterface

// ===== hdl/rvid_ctl_if.sv =====
interface rvid_ctl_if import rvid_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               legal;
    logic [ENTRY_W-1:0] entry;
    logic [FMT_W-1:0]   format;
    logic [SRC_W-1:0]   alu_source_a;
    logic [SRC_W-1:0]   alu_source_b;
    logic [OP_W-1:0]    alu_operation;
    logic [WB_W-1:0]    writeback_source;
    logic [MSZ_W-1:0]   mem_size;
    logic               mem_write;
    logic               mem_sign_extend;
    logic [CF_W-1:0]    control_flow;
    logic [CMP_W-1:0]   compare_op;

    modport source (
        output valid, output legal, output entry, output format,
        output alu_source_a, output alu_source_b, output alu_operation,
        output writeback_source, output mem_size, output mem_write,
        output mem_sign_extend, output control_flow, output compare_op,
        input ready
    );
    modport sink (
        input valid, input legal, input entry, input format,
        input alu_source_a, input alu_source_b, input alu_operation,
        input writeback_source, input mem_size, input mem_write,
        input mem_sign_extend, input control_flow, input compare_op,
        output ready
    );
endinterface

// ===== hdl/rvid_decode.sv =====
module rvid_decode import rvid_pkg::*; (
    input  logic [INSTR_W-1:0] i_instruction,
    output t_dec               o_dec
);

    logic [6:0]         w_opc;
    logic [2:0]         w_f3;
    logic [6:0]         w_f7;
    logic [11:0]        w_imm;
    logic [ENTRY_W-1:0] w_entry;

    assign w_opc = i_instruction[6:0];
    assign w_f3  = i_instruction[14:12];
    assign w_f7  = i_instruction[31:25];
    assign w_imm = i_instruction[31:20];

    always_comb begin
        w_entry = E_UNKNOWN;
        unique case (w_opc)
            OPC_LUI:      w_entry = E_LUI;
            OPC_AUIPC:    w_entry = E_AUIPC;
            OPC_JAL:      w_entry = E_JAL;
            OPC_JALR:     w_entry = (w_f3 == F3_0) ? E_JALR : E_UNKNOWN;
            OPC_BRANCH: begin
                unique case (w_f3)
                    F3_0:    w_entry = E_BEQ;
                    F3_1:    w_entry = E_BNE;
                    F3_4:    w_entry = E_BLT;
                    F3_5:    w_entry = E_BGE;
                    F3_6:    w_entry = E_BLTU;
                    F3_7:    w_entry = E_BGEU;
                    default: w_entry = E_UNKNOWN;
                endcase
            end
            OPC_LOAD: begin
                unique case (w_f3)
                    F3_0:    w_entry = E_LB;
                    F3_1:    w_entry = E_LH;
                    F3_2:    w_entry = E_LW;
                    F3_4:    w_entry = E_LBU;
                    F3_5:    w_entry = E_LHU;
                    default: w_entry = E_UNKNOWN;
                endcase
            end
            OPC_STORE: begin
                unique case (w_f3)
                    F3_0:    w_entry = E_SB;
                    F3_1:    w_entry = E_SH;
                    F3_2:    w_entry = E_SW;
                    default: w_entry = E_UNKNOWN;
                endcase
            end
            OPC_OP_IMM: begin
                unique case (w_f3)
                    F3_0:    w_entry = E_ADDI;
                    F3_1:    w_entry = (w_f7 == FUNCT7_ZERO) ? E_SLLI : E_UNKNOWN;
                    F3_2:    w_entry = E_SLTI;
                    F3_3:    w_entry = E_SLTIU;
                    F3_4:    w_entry = E_XORI;
                    F3_5: begin
                        if (w_f7 == FUNCT7_ZERO) begin
                            w_entry = E_SRLI;
                        end else if (w_f7 == FUNCT7_ALT) begin
                            w_entry = E_SRAI;
                        end else begin
                            w_entry = E_UNKNOWN;
                        end
                    end
                    F3_6:    w_entry = E_ORI;
                    default: w_entry = E_ANDI;
                endcase
            end
            OPC_OP: begin
                if (w_f7 == FUNCT7_ZERO) begin
                    unique case (w_f3)
                        F3_0:    w_entry = E_ADD;
                        F3_1:    w_entry = E_SLL;
                        F3_2:    w_entry = E_SLT;
                        F3_3:    w_entry = E_SLTU;
                        F3_4:    w_entry = E_XOR;
                        F3_5:    w_entry = E_SRL;
                        F3_6:    w_entry = E_OR;
                        default: w_entry = E_AND;
                    endcase
                end else if (w_f7 == FUNCT7_ALT && w_f3 == F3_0) begin
                    w_entry = E_SUB;
                end else if (w_f7 == FUNCT7_ALT && w_f3 == F3_5) begin
                    w_entry = E_SRA;
                end else begin
                    w_entry = E_UNKNOWN;
                end
            end
            OPC_MISC_MEM: w_entry = E_FENCE;
            OPC_SYSTEM: begin
                if (w_imm == IMM_ECALL) begin
                    w_entry = E_ECALL;
                end else if (w_imm == IMM_EBREAK) begin
                    w_entry = E_EBREAK;
                end else begin
                    w_entry = E_UNKNOWN;
                end
            end
            default:      w_entry = E_UNKNOWN;
        endcase
    end

    assign o_dec.legal = (w_entry != E_UNKNOWN);
    assign o_dec.entry = w_entry;
    assign o_dec.row   = ctl_lookup(w_entry);

endmodule

// ===== hdl/rv32i_instruction_decoder.sv =====
// rv32i instruction decoder
// an instruction request passes through the input register and then the result register to the control word
// throughput: one request per cycle while the result side is ready; decode is a single combinational pass between them
// a stalled result holds in the result register while the input register keeps one more
// reset: synchronous active-low i_rst_n empties both stages, no other state
module rv32i_instruction_decoder import rvid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvid_instr_if.sink  i_instr,
    rvid_ctl_if.source  o_ctl
);

    logic               r_in_valid;
    logic [INSTR_W-1:0] r_instr;
    logic               r_out_valid;
    t_dec               r_res;
    t_dec               w_dec;
    logic               w_adv_out;
    logic               w_adv_in;
    logic               w_in_fire;

    assign w_adv_out     = !r_out_valid || o_ctl.ready;
    assign w_adv_in      = !r_in_valid || w_adv_out;
    assign w_in_fire     = i_instr.valid && w_adv_in;
    assign i_instr.ready = w_adv_in;

    rvid_decode u_decode (
        .i_instruction (r_instr),
        .o_dec         (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv_in) begin
                r_in_valid <= i_instr.valid;
            end
            if (w_adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_instr <= i_instr.instruction;
        end
        if (r_in_valid && w_adv_out) begin
            r_res <= w_dec;
        end
    end

    assign o_ctl.valid            = r_out_valid;
    assign o_ctl.legal            = r_res.legal;
    assign o_ctl.entry            = r_res.entry;
    assign o_ctl.format           = r_res.row.fmt;
    assign o_ctl.alu_source_a     = r_res.row.src_a;
    assign o_ctl.alu_source_b     = r_res.row.src_b;
    assign o_ctl.alu_operation    = r_res.row.alu_op;
    assign o_ctl.writeback_source = r_res.row.wb;
    assign o_ctl.mem_size         = r_res.row.msz;
    assign o_ctl.mem_write        = r_res.row.mw;
    assign o_ctl.mem_sign_extend  = r_res.row.mse;
    assign o_ctl.control_flow     = r_res.row.cf;
    assign o_ctl.compare_op       = r_res.row.cmp;

    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_in_valid)
        else $error("accepted request not held in input stage");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv_out) |=> r_out_valid)
        else $error("decoded request lost between stages");

    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.legal) |->
        (r_res.entry == E_UNKNOWN && r_res.row.fmt == FMT_UNK &&
         r_res.row.wb == WB_NONE && r_res.row.cf == CF_NONE && !r_res.row.mw))
        else $error("unknown instruction carries controls");

    a_store_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.row.mw) |->
        (r_res.row.fmt == FMT_S && r_res.row.wb == WB_NONE && r_res.row.msz != MSZ_NONE))
        else $error("store control word inconsistent");

endmodule

// ===== test/rv32i_instruction_decoder_tb.sv =====
module rv32i_instruction_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rvid_pkg::*;

    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [INSTR_W-1:0] word;
        t_dec               ctl;
    } t_decoded_request;

    logic i_clk;
    logic i_rst_n;

    rvid_instr_if instr_bus ();
    rvid_ctl_if   ctl_bus ();

    rv32i_instruction_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (instr_bus),
        .o_ctl   (ctl_bus)
    );

    t_decoded_request controls_due[$];
    int unsigned      mismatch_count;
    int unsigned      cycles_run;
    bit               bursts_on;
    bit               hold_off_pending;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // control word the decoder should give for one instruction
    function automatic t_dec predict_control_word(input logic [INSTR_W-1:0] w);
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [11:0] imm;
        t_dec        d;
        opc = w[6:0];
        f3  = w[14:12];
        f7  = w[31:25];
        imm = w[31:20];
        d = '0;
        d.entry = E_UNKNOWN;
        case (opc)
            OPC_LUI:   d.entry = E_LUI;
            OPC_AUIPC: d.entry = E_AUIPC;
            OPC_JAL:   d.entry = E_JAL;
            OPC_JALR:  if (f3 == F3_0) d.entry = E_JALR;
            OPC_BRANCH: begin
                case (f3)
                    F3_0: d.entry = E_BEQ;
                    F3_1: d.entry = E_BNE;
                    F3_4: d.entry = E_BLT;
                    F3_5: d.entry = E_BGE;
                    F3_6: d.entry = E_BLTU;
                    F3_7: d.entry = E_BGEU;
                    default: d.entry = E_UNKNOWN;
                endcase
            end
            OPC_LOAD: begin
                case (f3)
                    F3_0: d.entry = E_LB;
                    F3_1: d.entry = E_LH;
                    F3_2: d.entry = E_LW;
                    F3_4: d.entry = E_LBU;
                    F3_5: d.entry = E_LHU;
                    default: d.entry = E_UNKNOWN;
                endcase
            end
            OPC_STORE: begin
                case (f3)
                    F3_0: d.entry = E_SB;
                    F3_1: d.entry = E_SH;
                    F3_2: d.entry = E_SW;
                    default: d.entry = E_UNKNOWN;
                endcase
            end
            OPC_OP_IMM: begin
                case (f3)
                    F3_0: d.entry = E_ADDI;
                    F3_1: if (f7 == FUNCT7_ZERO) d.entry = E_SLLI;
                    F3_2: d.entry = E_SLTI;
                    F3_3: d.entry = E_SLTIU;
                    F3_4: d.entry = E_XORI;
                    F3_5: begin
                        if (f7 == FUNCT7_ZERO) d.entry = E_SRLI;
                        else if (f7 == FUNCT7_ALT) d.entry = E_SRAI;
                    end
                    F3_6: d.entry = E_ORI;
                    default: d.entry = E_ANDI;
                endcase
            end
            OPC_OP: begin
                if (f7 == FUNCT7_ZERO) begin
                    case (f3)
                        F3_0: d.entry = E_ADD;
                        F3_1: d.entry = E_SLL;
                        F3_2: d.entry = E_SLT;
                        F3_3: d.entry = E_SLTU;
                        F3_4: d.entry = E_XOR;
                        F3_5: d.entry = E_SRL;
                        F3_6: d.entry = E_OR;
                        default: d.entry = E_AND;
                    endcase
                end else if (f7 == FUNCT7_ALT) begin
                    if (f3 == F3_0) d.entry = E_SUB;
                    else if (f3 == F3_5) d.entry = E_SRA;
                end
            end
            OPC_MISC_MEM: d.entry = E_FENCE;
            OPC_SYSTEM: begin
                if (imm == IMM_ECALL) d.entry = E_ECALL;
                else if (imm == IMM_EBREAK) d.entry = E_EBREAK;
            end
            default: d.entry = E_UNKNOWN;
        endcase

        d.legal = (d.entry != E_UNKNOWN);
        case (d.entry)
            E_LUI, E_AUIPC: begin
                d.row.fmt    = FMT_U;
                d.row.src_a  = (d.entry == E_AUIPC) ? SRC_PC : SRC_NONE;
                d.row.src_b  = SRC_IMM;
                d.row.alu_op = (d.entry == E_AUIPC) ? ALU_ADD : ALU_PASS_B;
                d.row.wb     = WB_ALU;
            end
            E_JAL: begin
                d.row.fmt = FMT_J;
                d.row.wb  = WB_PC;
                d.row.cf  = CF_JUMP;
            end
            E_JALR: begin
                d.row.fmt = FMT_I;
                d.row.wb  = WB_PC;
                d.row.cf  = CF_JREG;
            end
            E_BEQ, E_BNE, E_BLT, E_BGE, E_BLTU, E_BGEU: begin
                d.row.fmt = FMT_B;
                d.row.cf  = CF_BRANCH;
            end
            E_LB, E_LH, E_LW, E_LBU, E_LHU: begin
                d.row.fmt    = FMT_I;
                d.row.src_a  = SRC_REG;
                d.row.src_b  = SRC_IMM;
                d.row.alu_op = ALU_ADD;
                d.row.wb     = WB_MEM;
                d.row.mse    = (d.entry == E_LB) || (d.entry == E_LH);
            end
            E_SB, E_SH, E_SW: begin
                d.row.fmt    = FMT_S;
                d.row.src_a  = SRC_REG;
                d.row.src_b  = SRC_IMM;
                d.row.alu_op = ALU_ADD;
                d.row.mw     = 1'b1;
            end
            E_ADDI, E_SLTI, E_SLTIU, E_XORI, E_ORI, E_ANDI, E_SLLI, E_SRLI, E_SRAI: begin
                d.row.fmt   = FMT_I;
                d.row.src_a = SRC_REG;
                d.row.src_b = SRC_IMM;
                d.row.wb    = WB_ALU;
            end
            E_ADD, E_SUB, E_SLL, E_SLT, E_SLTU, E_XOR, E_SRL, E_SRA, E_OR, E_AND: begin
                d.row.fmt   = FMT_R;
                d.row.src_a = SRC_REG;
                d.row.src_b = SRC_REG;
                d.row.wb    = WB_ALU;
            end
            E_FENCE: d.row.fmt = FMT_I;
            E_ECALL, E_EBREAK: begin
                d.row.fmt = FMT_I;
                d.row.cf  = CF_TRAP;
            end
            default: d.row.fmt = FMT_UNK;
        endcase

        case (d.entry)
            E_ADDI, E_ADD:  d.row.alu_op = ALU_ADD;
            E_SUB:          d.row.alu_op = ALU_SUB;
            E_SLLI, E_SLL:  d.row.alu_op = ALU_SLL;
            E_SLTI, E_SLT:  d.row.alu_op = ALU_SLT;
            E_SLTIU, E_SLTU: d.row.alu_op = ALU_SLTU;
            E_XORI, E_XOR:  d.row.alu_op = ALU_XOR;
            E_SRLI, E_SRL:  d.row.alu_op = ALU_SRL;
            E_SRAI, E_SRA:  d.row.alu_op = ALU_SRA;
            E_ORI, E_OR:    d.row.alu_op = ALU_OR;
            E_ANDI, E_AND:  d.row.alu_op = ALU_AND;
            default: ;
        endcase

        case (d.entry)
            E_LB, E_LBU, E_SB: d.row.msz = MSZ_BYTE;
            E_LH, E_LHU, E_SH: d.row.msz = MSZ_HALF;
            E_LW, E_SW:        d.row.msz = MSZ_WORD;
            default: ;
        endcase

        case (d.entry)
            E_BEQ:  d.row.cmp = CMP_EQ;
            E_BNE:  d.row.cmp = CMP_NE;
            E_BLT:  d.row.cmp = CMP_LT;
            E_BGE:  d.row.cmp = CMP_GE;
            E_BLTU: d.row.cmp = CMP_LTU;
            E_BGEU: d.row.cmp = CMP_GEU;
            default: ;
        endcase
        return d;
    endfunction

    // valid encoding of one instruction, every free bit random
    function automatic logic [INSTR_W-1:0] encode_instruction(input logic [ENTRY_W-1:0] e);
        logic [INSTR_W-1:0] w;
        w = $urandom;
        case (e)
            E_LUI:    w[6:0] = OPC_LUI;
            E_AUIPC:  w[6:0] = OPC_AUIPC;
            E_JAL:    w[6:0] = OPC_JAL;
            E_JALR:   w = {w[31:15], F3_0, w[11:7], OPC_JALR};
            E_BEQ:    w = {w[31:15], F3_0, w[11:7], OPC_BRANCH};
            E_BNE:    w = {w[31:15], F3_1, w[11:7], OPC_BRANCH};
            E_BLT:    w = {w[31:15], F3_4, w[11:7], OPC_BRANCH};
            E_BGE:    w = {w[31:15], F3_5, w[11:7], OPC_BRANCH};
            E_BLTU:   w = {w[31:15], F3_6, w[11:7], OPC_BRANCH};
            E_BGEU:   w = {w[31:15], F3_7, w[11:7], OPC_BRANCH};
            E_LB:     w = {w[31:15], F3_0, w[11:7], OPC_LOAD};
            E_LH:     w = {w[31:15], F3_1, w[11:7], OPC_LOAD};
            E_LW:     w = {w[31:15], F3_2, w[11:7], OPC_LOAD};
            E_LBU:    w = {w[31:15], F3_4, w[11:7], OPC_LOAD};
            E_LHU:    w = {w[31:15], F3_5, w[11:7], OPC_LOAD};
            E_SB:     w = {w[31:15], F3_0, w[11:7], OPC_STORE};
            E_SH:     w = {w[31:15], F3_1, w[11:7], OPC_STORE};
            E_SW:     w = {w[31:15], F3_2, w[11:7], OPC_STORE};
            E_ADDI:   w = {w[31:15], F3_0, w[11:7], OPC_OP_IMM};
            E_SLTI:   w = {w[31:15], F3_2, w[11:7], OPC_OP_IMM};
            E_SLTIU:  w = {w[31:15], F3_3, w[11:7], OPC_OP_IMM};
            E_XORI:   w = {w[31:15], F3_4, w[11:7], OPC_OP_IMM};
            E_ORI:    w = {w[31:15], F3_6, w[11:7], OPC_OP_IMM};
            E_ANDI:   w = {w[31:15], F3_7, w[11:7], OPC_OP_IMM};
            E_SLLI:   w = {FUNCT7_ZERO, w[24:15], F3_1, w[11:7], OPC_OP_IMM};
            E_SRLI:   w = {FUNCT7_ZERO, w[24:15], F3_5, w[11:7], OPC_OP_IMM};
            E_SRAI:   w = {FUNCT7_ALT, w[24:15], F3_5, w[11:7], OPC_OP_IMM};
            E_ADD:    w = {FUNCT7_ZERO, w[24:15], F3_0, w[11:7], OPC_OP};
            E_SUB:    w = {FUNCT7_ALT, w[24:15], F3_0, w[11:7], OPC_OP};
            E_SLL:    w = {FUNCT7_ZERO, w[24:15], F3_1, w[11:7], OPC_OP};
            E_SLT:    w = {FUNCT7_ZERO, w[24:15], F3_2, w[11:7], OPC_OP};
            E_SLTU:   w = {FUNCT7_ZERO, w[24:15], F3_3, w[11:7], OPC_OP};
            E_XOR:    w = {FUNCT7_ZERO, w[24:15], F3_4, w[11:7], OPC_OP};
            E_SRL:    w = {FUNCT7_ZERO, w[24:15], F3_5, w[11:7], OPC_OP};
            E_SRA:    w = {FUNCT7_ALT, w[24:15], F3_5, w[11:7], OPC_OP};
            E_OR:     w = {FUNCT7_ZERO, w[24:15], F3_6, w[11:7], OPC_OP};
            E_AND:    w = {FUNCT7_ZERO, w[24:15], F3_7, w[11:7], OPC_OP};
            E_FENCE:  w[6:0] = OPC_MISC_MEM;
            E_ECALL:  w = {IMM_ECALL, w[19:7], OPC_SYSTEM};
            E_EBREAK: w = {IMM_EBREAK, w[19:7], OPC_SYSTEM};
            default: ;
        endcase
        return w;
    endfunction

    // mostly valid encodings, the rest near misses and raw noise
    function automatic logic [INSTR_W-1:0] random_instruction();
        logic [INSTR_W-1:0] w;
        int unsigned        pick;
        int unsigned        bit_pos;
        w = encode_instruction(ENTRY_W'($urandom_range(E_LUI, E_EBREAK)));
        pick = $urandom_range(0, 99);
        bit_pos = $urandom_range(0, 6);
        if (pick < 10) w[14:12] = 3'($urandom_range(0, 7));
        else if (pick < 17) w[31:25] = 7'($urandom_range(0, 127));
        else if (pick < 22) w[31:20] = 12'($urandom_range(0, 3));
        else if (pick < 27) w[bit_pos] = ~w[bit_pos];
        else if (pick < 35) w = $urandom;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100) $display("ERROR: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [INSTR_W-1:0] word,
                                 input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s of %08h: got %0d, expected %0d",
                                      name, word, got, want));
    endtask

    task automatic send_instruction(input logic [INSTR_W-1:0] word);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            instr_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        instr_bus.valid       <= 1'b1;
        instr_bus.instruction <= word;
        do @(posedge i_clk); while (!instr_bus.ready);
    endtask

    task automatic wait_for_all_controls();
        instr_bus.valid <= 1'b0;
        do @(posedge i_clk); while (controls_due.size() != 0);
    endtask

    task automatic test_edge_encodings();
        send_instruction(32'h0000_0000);  // opcode zero
        send_instruction(32'hFFFF_FFFF);  // all ones
        send_instruction(32'hFFFF_FFB7);  // lui, every free bit set
        send_instruction(32'h0000_0017);  // auipc, every free bit clear
        send_instruction(32'hFFFF_FFEF);  // jal
        send_instruction(32'hFFFF_8FE7);  // jalr
        send_instruction(32'h0000_1067);  // jalr with nonzero funct3
        send_instruction(32'h0000_0063);  // beq
        send_instruction(32'h0000_2063);  // branch funct3 hole
        send_instruction(32'hFFFF_FFE3);  // bgeu
        send_instruction(32'h0000_3003);  // load funct3 hole
        send_instruction(32'hFFFF_FF83);  // load funct3 hole, top
        send_instruction(32'h0000_3023);  // store funct3 hole
        send_instruction(32'h0000_2023);  // sw
        send_instruction(32'h4000_1013);  // slli with alternate funct7
        send_instruction(32'h4000_5013);  // srai
        send_instruction(32'h0200_5013);  // shift immediate, other funct7
        send_instruction(32'h4000_0033);  // sub
        send_instruction(32'h4000_5033);  // sra
        send_instruction(32'h4000_1033);  // sll with alternate funct7
        send_instruction(32'h0200_0033);  // op with other funct7
        send_instruction(32'hFFFF_FF8F);  // fence, every other bit set
        send_instruction(32'h000F_FFF3);  // ecall with junk rd, rs1, funct3
        send_instruction(32'h0010_0073);  // ebreak
        send_instruction(32'h0020_0073);  // system imm past ebreak
        send_instruction(32'hFFF0_0073);  // system imm all ones
    endtask

    task automatic test_every_instruction();
        for (int e = E_LUI; e <= E_EBREAK; e++)
            send_instruction(encode_instruction(ENTRY_W'(e)));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        repeat (count) send_instruction(random_instruction());
    endtask

    task automatic test_result_hold_off();
        hold_off_pending = 1'b1;
        repeat (40) send_instruction(random_instruction());
    endtask

    task automatic test_drain_and_resume();
        repeat (60) send_instruction(random_instruction());
        wait_for_all_controls();
        repeat (60) send_instruction(random_instruction());
    endtask

    task automatic test_steady_stream();
        bursts_on = 1'b0;
        repeat (300) send_instruction(random_instruction());
    endtask

    // result side, stalls in bursts or one long hold-off
    initial begin : control_consumer
        int unsigned held;
        ctl_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                ctl_bus.ready <= 1'b0;
                held = 0;
                while (held < HOLD_OFF_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_off_pending = 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                ctl_bus.ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(posedge i_clk);
            end else begin
                ctl_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : request_checker
        t_decoded_request req;
        t_decoded_request oldest;
        if (i_rst_n && instr_bus.valid && instr_bus.ready) begin
            req.word = instr_bus.instruction;
            req.ctl  = predict_control_word(instr_bus.instruction);
            controls_due.push_back(req);
        end
        if (i_rst_n && ctl_bus.valid && ctl_bus.ready) begin
            if (controls_due.size() == 0) begin
                report_mismatch($sformatf("control word with no request pending, entry %0d",
                                          ctl_bus.entry));
            end else begin
                oldest = controls_due.pop_front();
                compare_field("legal", oldest.word, 8'(ctl_bus.legal),
                              8'(oldest.ctl.legal));
                compare_field("entry", oldest.word, 8'(ctl_bus.entry),
                              8'(oldest.ctl.entry));
                compare_field("format", oldest.word, 8'(ctl_bus.format),
                              8'(oldest.ctl.row.fmt));
                compare_field("alu_source_a", oldest.word, 8'(ctl_bus.alu_source_a),
                              8'(oldest.ctl.row.src_a));
                compare_field("alu_source_b", oldest.word, 8'(ctl_bus.alu_source_b),
                              8'(oldest.ctl.row.src_b));
                compare_field("alu_operation", oldest.word, 8'(ctl_bus.alu_operation),
                              8'(oldest.ctl.row.alu_op));
                compare_field("writeback_source", oldest.word, 8'(ctl_bus.writeback_source),
                              8'(oldest.ctl.row.wb));
                compare_field("mem_size", oldest.word, 8'(ctl_bus.mem_size),
                              8'(oldest.ctl.row.msz));
                compare_field("mem_write", oldest.word, 8'(ctl_bus.mem_write),
                              8'(oldest.ctl.row.mw));
                compare_field("mem_sign_extend", oldest.word, 8'(ctl_bus.mem_sign_extend),
                              8'(oldest.ctl.row.mse));
                compare_field("control_flow", oldest.word, 8'(ctl_bus.control_flow),
                              8'(oldest.ctl.row.cf));
                compare_field("compare_op", oldest.word, 8'(ctl_bus.compare_op),
                              8'(oldest.ctl.row.cmp));
            end
        end
    end

    initial begin : watchdog
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("rv32i_instruction_decoder: mismatch");
        $finish;
    end

    initial begin
        mismatch_count        = 0;
        bursts_on             = 1'b1;
        hold_off_pending      = 1'b0;
        i_rst_n               <= 1'b0;
        instr_bus.valid       <= 1'b0;
        instr_bus.instruction <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_encodings();
        test_every_instruction();
        test_random_traffic(1000);
        test_result_hold_off();
        test_drain_and_resume();
        test_steady_stream();

        wait_for_all_controls();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && controls_due.size() == 0) begin
            $display("rv32i_instruction_decoder: match");
        end else begin
            $display("rv32i_instruction_decoder: mismatch");
        end
        $finish;
    end

endmodule
